>>> hw/rtl/ccc_pkg.sv
// Shared types for the circle-circle collision pipeline.
`default_nettype none
package ccc_pkg;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 17;
  localparam logic signed [17:0] NormOne = 18'sd65536;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [29:0]        ra;
    logic [30:0]        rsum;
    logic               hit;
    logic               coin;
  } ccc_item_t;

  typedef struct packed {
    ccc_item_t   item;
    logic [63:0] s;
    logic [33:0] rem;
    logic [31:0] root;
  } ccc_sqrt_t;

  typedef struct packed {
    ccc_item_t   item;
    logic [31:0] d;
    logic [31:0] rem_x;
    logic [31:0] rem_y;
    logic [16:0] num_x;
    logic [16:0] num_y;
    logic [16:0] q_x;
    logic [16:0] q_y;
  } ccc_div_t;

endpackage
`default_nettype wire

>>> hw/rtl/ccc_sqrt_stage.sv
// One registered step of the digit-by-digit square root.
`default_nettype none
module ccc_sqrt_stage
  import ccc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire logic      valid_i,
  input  wire ccc_sqrt_t data_i,
  output logic           valid_o,
  output ccc_sqrt_t      data_o
);

  logic [35:0] rem_sh;
  logic [35:0] trial;
  ccc_sqrt_t   data_d;
  ccc_sqrt_t   data_q;
  logic        valid_q;

  always_comb begin
    rem_sh = {data_i.rem, data_i.s[63:62]};
    trial  = {2'b00, data_i.root, 2'b01};
    data_d = data_i;
    data_d.s = {data_i.s[61:0], 2'b00};
    if (rem_sh >= trial) begin
      data_d.rem  = 34'(rem_sh - trial);
      data_d.root = {data_i.root[30:0], 1'b1};
    end else begin
      data_d.rem  = rem_sh[33:0];
      data_d.root = {data_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

>>> hw/rtl/ccc_div_stage.sv
// One registered restoring-division step for both normal components.
`default_nettype none
module ccc_div_stage
  import ccc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire logic     valid_i,
  input  wire ccc_div_t data_i,
  output logic          valid_o,
  output ccc_div_t      data_o
);

  logic [32:0] sh_x;
  logic [32:0] sh_y;
  logic [32:0] dv;
  ccc_div_t    data_d;
  ccc_div_t    data_q;
  logic        valid_q;

  always_comb begin
    sh_x   = {data_i.rem_x, data_i.num_x[16]};
    sh_y   = {data_i.rem_y, data_i.num_y[16]};
    dv     = {1'b0, data_i.d};
    data_d = data_i;
    data_d.num_x = {data_i.num_x[15:0], 1'b0};
    data_d.num_y = {data_i.num_y[15:0], 1'b0};
    if (sh_x >= dv) begin
      data_d.rem_x = 32'(sh_x - dv);
      data_d.q_x   = {data_i.q_x[15:0], 1'b1};
    end else begin
      data_d.rem_x = sh_x[31:0];
      data_d.q_x   = {data_i.q_x[15:0], 1'b0};
    end
    if (sh_y >= dv) begin
      data_d.rem_y = 32'(sh_y - dv);
      data_d.q_y   = {data_i.q_y[15:0], 1'b1};
    end else begin
      data_d.rem_y = sh_y[31:0];
      data_d.q_y   = {data_i.q_y[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

>>> hw/rtl/circle_circle_collision_core.sv
// Top level: pipelined two-circle overlap test with normal, depth and contact point.
//
//   channel | direction | handshake               | payload
//   in      | request   | in_valid_i / in_stall_o | a_*, b_* centers and radii
//   out     | result    | out_valid_o / out_stall_i | hit, normal, depth, contact
//   cfg     | write     | cfg_valid_i / cfg_ready_o | coincidence threshold
//
// One request per cycle when not stalled. Stages: 3 setup, 32 square-root steps,
// 1 divide setup, 17 divide steps, 1 multiply, 1 round/saturate into output.
// The whole pipeline advances together; it holds only while a result waits
// on out_stall_i, and an empty output slot never holds it. Reset clears valid
// bits and sets the threshold to 66.
`default_nettype none
module circle_circle_collision_core
  import ccc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] a_center_x_i,
  input  wire logic signed [31:0] a_center_y_i,
  input  wire logic [29:0]        a_radius_i,
  input  wire logic signed [31:0] b_center_x_i,
  input  wire logic signed [31:0] b_center_y_i,
  input  wire logic [29:0]        b_radius_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    hit_o,
  output logic signed [17:0]      normal_x_o,
  output logic signed [17:0]      normal_y_o,
  output logic [30:0]             depth_o,
  output logic signed [31:0]      contact_x_o,
  output logic signed [31:0]      contact_y_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [15:0]        cfg_wdata_i
);

  logic        en;
  logic [31:0] thr_sq_q;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_sq_q <= 32'd4356;
    end else if (cfg_valid_i) begin
      thr_sq_q <= 32'(cfg_wdata_i) * 32'(cfg_wdata_i);
    end
  end

  // setup stage 1: offsets and radius sum
  ccc_item_t s1_q;
  logic      s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.dx   <= 33'(b_center_x_i) - 33'(a_center_x_i);
      s1_q.dy   <= 33'(b_center_y_i) - 33'(a_center_y_i);
      s1_q.ax   <= a_center_x_i;
      s1_q.ay   <= a_center_y_i;
      s1_q.ra   <= a_radius_i;
      s1_q.rsum <= 31'(a_radius_i) + 31'(b_radius_i);
      s1_q.hit  <= 1'b0;
      s1_q.coin <= 1'b0;
    end
  end

  // setup stage 2: squares
  logic [32:0] mx1, my1;
  ccc_item_t   s2_q;
  logic        s2_v_q;
  logic [61:0] sqx_q, sqy_q, rsq_q;
  logic        far_q;

  assign mx1 = s1_q.dx[32] ? 33'(-s1_q.dx) : 33'(s1_q.dx);
  assign my1 = s1_q.dy[32] ? 33'(-s1_q.dy) : 33'(s1_q.dy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q  <= s1_q;
      sqx_q <= 62'(mx1[30:0]) * 62'(mx1[30:0]);
      sqy_q <= 62'(my1[30:0]) * 62'(my1[30:0]);
      rsq_q <= 62'(s1_q.rsum) * 62'(s1_q.rsum);
      far_q <= (mx1[32:31] != 2'b00) || (my1[32:31] != 2'b00);
    end
  end

  // setup stage 3: sum of squares and compares
  logic [62:0] ssum;
  ccc_item_t   it3;
  ccc_sqrt_t   sq [0:SqrtSteps];
  logic        sq_v [0:SqrtSteps];

  assign ssum = 63'(sqx_q) + 63'(sqy_q);

  always_comb begin
    it3      = s2_q;
    it3.hit  = !far_q && (ssum < 63'(rsq_q));
    it3.coin = ssum < 63'(thr_sq_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq[0].item <= it3;
      sq[0].s    <= {1'b0, ssum};
      sq[0].rem  <= '0;
      sq[0].root <= '0;
    end
  end

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    ccc_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .data_i  (sq[i]),
      .valid_o (sq_v[i+1]),
      .data_o  (sq[i+1])
    );
  end

  // divide setup: rounded numerators
  ccc_item_t   it_r;
  logic [31:0] d_r;
  logic [30:0] mxr, myr;
  logic [47:0] numx, numy;
  ccc_div_t    dv [0:DivSteps];
  logic        dv_v [0:DivSteps];

  assign it_r = sq[SqrtSteps].item;
  assign d_r  = sq[SqrtSteps].root;
  assign mxr  = it_r.dx[32] ? 31'(-it_r.dx) : it_r.dx[30:0];
  assign myr  = it_r.dy[32] ? 31'(-it_r.dy) : it_r.dy[30:0];
  assign numx = {1'b0, mxr, 16'b0} + 48'(d_r[31:1]);
  assign numy = {1'b0, myr, 16'b0} + 48'(d_r[31:1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv[0].item  <= it_r;
      dv[0].d     <= d_r;
      dv[0].rem_x <= {1'b0, numx[47:17]};
      dv[0].rem_y <= {1'b0, numy[47:17]};
      dv[0].num_x <= numx[16:0];
      dv[0].num_y <= numy[16:0];
      dv[0].q_x   <= '0;
      dv[0].q_y   <= '0;
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    ccc_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[j]),
      .data_i  (dv[j]),
      .valid_o (dv_v[j+1]),
      .data_o  (dv[j+1])
    );
  end

  // signed normal and radius product
  ccc_div_t                dl;
  logic signed [17:0]      nx_c, ny_c;
  ccc_item_t               m_q;
  logic [31:0]             m_d_q;
  logic signed [17:0]      nx_q, ny_q;
  logic signed [47:0]      px_q, py_q;
  logic                    m_v_q;

  assign dl   = dv[DivSteps];
  assign nx_c = dl.item.dx[32] ? -$signed({1'b0, dl.q_x}) : $signed({1'b0, dl.q_x});
  assign ny_c = dl.item.dy[32] ? -$signed({1'b0, dl.q_y}) : $signed({1'b0, dl.q_y});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= dv_v[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q   <= dl.item;
      m_d_q <= dl.d;
      nx_q  <= nx_c;
      ny_q  <= ny_c;
      px_q  <= 48'(nx_c) * 48'($signed({1'b0, dl.item.ra}));
      py_q  <= 48'(ny_c) * 48'($signed({1'b0, dl.item.ra}));
    end
  end

  // round, add center, saturate, select
  logic [47:0]        magx, magy;
  logic [31:0]        rx, ry;
  logic signed [33:0] adjx, adjy, sumx, sumy;
  logic signed [31:0] cx_sat, cy_sat;
  logic               coin_f;

  assign magx = px_q[47] ? 48'(-px_q) : 48'(px_q);
  assign magy = py_q[47] ? 48'(-py_q) : 48'(py_q);
  assign rx   = 32'((magx + 48'd32768) >> 16);
  assign ry   = 32'((magy + 48'd32768) >> 16);
  assign adjx = px_q[47] ? -$signed({2'b00, rx}) : $signed({2'b00, rx});
  assign adjy = py_q[47] ? -$signed({2'b00, ry}) : $signed({2'b00, ry});
  assign sumx = 34'(m_q.ax) + adjx;
  assign sumy = 34'(m_q.ay) + adjy;

  always_comb begin
    if (sumx > 34'sd2147483647) begin
      cx_sat = 32'sh7FFFFFFF;
    end else if (sumx < -34'sd2147483648) begin
      cx_sat = 32'sh80000000;
    end else begin
      cx_sat = sumx[31:0];
    end
    if (sumy > 34'sd2147483647) begin
      cy_sat = 32'sh7FFFFFFF;
    end else if (sumy < -34'sd2147483648) begin
      cy_sat = 32'sh80000000;
    end else begin
      cy_sat = sumy[31:0];
    end
  end

  assign coin_f = m_q.coin || (m_d_q == '0);

  logic               out_v_q;
  logic               hit_q;
  logic signed [17:0] onx_q, ony_q;
  logic [30:0]        depth_q;
  logic signed [31:0] ocx_q, ocy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!m_q.hit) begin
        hit_q   <= 1'b0;
        onx_q   <= '0;
        ony_q   <= '0;
        depth_q <= '0;
        ocx_q   <= '0;
        ocy_q   <= '0;
      end else if (coin_f) begin
        hit_q   <= 1'b1;
        onx_q   <= NormOne;
        ony_q   <= '0;
        depth_q <= m_q.rsum;
        ocx_q   <= m_q.ax;
        ocy_q   <= m_q.ay;
      end else begin
        hit_q   <= 1'b1;
        onx_q   <= nx_q;
        ony_q   <= ny_q;
        depth_q <= 31'(m_q.rsum - 31'(m_d_q));
        ocx_q   <= cx_sat;
        ocy_q   <= cy_sat;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign hit_o       = hit_q;
  assign normal_x_o  = onx_q;
  assign normal_y_o  = ony_q;
  assign depth_o     = depth_q;
  assign contact_x_o = ocx_q;
  assign contact_y_o = ocy_q;

endmodule
`default_nettype wire
